// ===== hdl/rwss_pkg.sv =====
// Package for the random-walk sensor stimulus block.
// Holds register indexes, arithmetic constants, the sequencer state type and
// the command/status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package rwss_pkg;

    // Register map (index = paddr[4:2])
    localparam logic [2:0] REG_SEED_START       = 3'd0;
    localparam logic [2:0] REG_TEMP_DRIFT       = 3'd1;
    localparam logic [2:0] REG_TEMP_NOISE_RANGE = 3'd2;
    localparam logic [2:0] REG_TEMP_SPIKE_RANGE = 3'd3;
    localparam logic [2:0] REG_PRES_DRIFT       = 3'd4;
    localparam logic [2:0] REG_PRES_NOISE_RANGE = 3'd5;
    localparam logic [2:0] REG_PRES_SPIKE_RANGE = 3'd6;
    localparam logic [2:0] REG_SPIKE_PERCENT    = 3'd7;

    // Register reset values
    localparam logic [30:0]        SEED_START_RST       = 31'd12345;
    localparam logic signed [15:0] TEMP_DRIFT_RST       = 16'sd38;
    localparam logic [15:0]        TEMP_NOISE_RANGE_RST = 16'd512;
    localparam logic [15:0]        TEMP_SPIKE_RANGE_RST = 16'd3840;
    localparam logic signed [15:0] PRES_DRIFT_RST       = 16'sd13;
    localparam logic [15:0]        PRES_NOISE_RANGE_RST = 16'd128;
    localparam logic [15:0]        PRES_SPIKE_RANGE_RST = 16'd768;
    localparam logic [6:0]         SPIKE_PERCENT_RST    = 7'd3;

    // Generator
    localparam logic [30:0] LCG_MUL = 31'd1103515245;
    localparam logic [30:0] LCG_ADD = 31'd12345;

    // Deviation divisor 2^15-1 and reciprocal of 100 (scaled by 2^19)
    localparam logic [14:0] DRAW_FULL  = 15'd32767;
    localparam logic [12:0] RECIP_100  = 13'd5243;

    // Walk state reset values
    localparam logic signed [16:0] TEMP_VALUE_RST = 17'sd6400;
    localparam logic signed [13:0] PRES_VALUE_RST = 14'sd768;

    // Clamp and saturation bounds, 19-bit signed working width
    localparam logic signed [18:0] TEMP_MIN = -19'sd2560;
    localparam logic signed [18:0] TEMP_MAX = 19'sd30720;
    localparam logic signed [18:0] PRES_MIN = 19'sd0;
    localparam logic signed [18:0] PRES_MAX = 19'sd3840;
    localparam logic signed [18:0] TEMP_SAT_MIN = -19'sd65536;
    localparam logic signed [18:0] TEMP_SAT_MAX = 19'sd65535;
    localparam logic signed [18:0] PRES_SAT_MIN = -19'sd8192;
    localparam logic signed [18:0] PRES_SAT_MAX = 19'sd8191;

    localparam logic CHAN_TEMP = 1'b0;
    localparam logic CHAN_PRES = 1'b1;

    typedef struct packed {
        logic [30:0]        seed_start;
        logic signed [15:0] temp_drift;
        logic [15:0]        temp_noise_range;
        logic [15:0]        temp_spike_range;
        logic signed [15:0] pres_drift;
        logic [15:0]        pres_noise_range;
        logic [15:0]        pres_spike_range;
        logic [6:0]         spike_percent;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NLCG,
        S_NMUL,
        S_NDIV,
        S_NACC,
        S_SLCG,
        S_MODQ,
        S_MODT,
        S_XLCG,
        S_XMUL,
        S_XDIV,
        S_XACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic lcg_step;
        logic dev_mul;
        logic spike_sel;
        logic dev_div;
        logic mod_q;
        logic mod_test;
        logic acc_noise;
        logic acc_spike;
        logic load_out;
        logic chan;
    } cmd_t;

    typedef struct packed {
        logic spike_hit;
    } sts_t;

endpackage

// ===== hdl/rwss_regs.sv =====
// Configuration register file with APB-style access.
// Depends on rwss_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module rwss_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rwss_pkg::cfg_t      cfg,
    output logic                seed_load,
    output logic [30:0]         seed_wdata
);

    rwss_pkg::cfg_t cfg_reg;
    rwss_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready     = 1'b1;
    assign idx        = paddr[4:2];
    assign wr_en      = psel && penable && pwrite;
    assign seed_load  = wr_en && (idx == rwss_pkg::REG_SEED_START);
    assign seed_wdata = pwdata[30:0];
    assign cfg        = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                rwss_pkg::REG_SEED_START:       cfg_next.seed_start       = pwdata[30:0];
                rwss_pkg::REG_TEMP_DRIFT:       cfg_next.temp_drift       = pwdata[15:0];
                rwss_pkg::REG_TEMP_NOISE_RANGE: cfg_next.temp_noise_range = pwdata[15:0];
                rwss_pkg::REG_TEMP_SPIKE_RANGE: cfg_next.temp_spike_range = pwdata[15:0];
                rwss_pkg::REG_PRES_DRIFT:       cfg_next.pres_drift       = pwdata[15:0];
                rwss_pkg::REG_PRES_NOISE_RANGE: cfg_next.pres_noise_range = pwdata[15:0];
                rwss_pkg::REG_PRES_SPIKE_RANGE: cfg_next.pres_spike_range = pwdata[15:0];
                rwss_pkg::REG_SPIKE_PERCENT:    cfg_next.spike_percent    = pwdata[6:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed_start       <= rwss_pkg::SEED_START_RST;
            cfg_reg.temp_drift       <= rwss_pkg::TEMP_DRIFT_RST;
            cfg_reg.temp_noise_range <= rwss_pkg::TEMP_NOISE_RANGE_RST;
            cfg_reg.temp_spike_range <= rwss_pkg::TEMP_SPIKE_RANGE_RST;
            cfg_reg.pres_drift       <= rwss_pkg::PRES_DRIFT_RST;
            cfg_reg.pres_noise_range <= rwss_pkg::PRES_NOISE_RANGE_RST;
            cfg_reg.pres_spike_range <= rwss_pkg::PRES_SPIKE_RANGE_RST;
            cfg_reg.spike_percent    <= rwss_pkg::SPIKE_PERCENT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back; signed drifts return sign-extended
    always_comb
    begin
        case (idx)
            rwss_pkg::REG_SEED_START:       prdata = {1'b0, cfg_reg.seed_start};
            rwss_pkg::REG_TEMP_DRIFT:       prdata = 32'(cfg_reg.temp_drift);
            rwss_pkg::REG_TEMP_NOISE_RANGE: prdata = {16'd0, cfg_reg.temp_noise_range};
            rwss_pkg::REG_TEMP_SPIKE_RANGE: prdata = {16'd0, cfg_reg.temp_spike_range};
            rwss_pkg::REG_PRES_DRIFT:       prdata = 32'(cfg_reg.pres_drift);
            rwss_pkg::REG_PRES_NOISE_RANGE: prdata = {16'd0, cfg_reg.pres_noise_range};
            rwss_pkg::REG_PRES_SPIKE_RANGE: prdata = {16'd0, cfg_reg.pres_spike_range};
            rwss_pkg::REG_SPIKE_PERCENT:    prdata = {25'd0, cfg_reg.spike_percent};
            default:                        prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/rwss_datapath.sv =====
// Datapath: generator, shared deviation multiply/divide, mod-100 test,
// walk accumulator and result registers. Depends on rwss_pkg.
`timescale 1ns / 1ps

module rwss_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  rwss_pkg::cfg_t      cfg,
    input  logic                seed_load,
    input  logic [30:0]         seed_wdata,
    input  rwss_pkg::cmd_t      cmd,
    output rwss_pkg::sts_t      sts,
    output logic signed [16:0]  temperature,
    output logic signed [13:0]  pressure,
    output logic                temp_spiked,
    output logic                pres_spiked
);

    logic [30:0]        seed_reg, seed_next, lcg_next;
    logic [14:0]        draw;
    logic               dev_neg;
    logic [14:0]        dev_mag;
    logic [15:0]        range_sel;
    logic [30:0]        prod_mag_reg;
    logic               prod_neg_reg;
    logic [15:0]        q0;
    logic [16:0]        r0;
    logic [1:0]         q1;
    logic [15:0]        r1;
    logic [16:0]        quot;
    logic signed [16:0] dev_reg;
    logic [27:0]        recip_prod;
    logic [8:0]         modq_reg;
    logic [15:0]        q_times_100;
    logic [14:0]        rem_full;
    logic [6:0]         rem;
    logic signed [18:0] val_ext, drift_ext, acc_sum, lo_bound, hi_bound, acc_bounded;
    logic signed [16:0] temp_reg;
    logic signed [13:0] pres_reg;
    logic               temp_flag_reg, pres_flag_reg;
    logic signed [16:0] temperature_reg;
    logic signed [13:0] pressure_reg;
    logic               temp_spiked_reg, pres_spiked_reg;

    // Generator: seed = seed * a + c mod 2^31
    assign lcg_next = seed_reg * rwss_pkg::LCG_MUL + rwss_pkg::LCG_ADD;
    assign draw     = seed_reg[30:16];

    always_comb
    begin
        seed_next = seed_reg;
        if (seed_load)
        begin
            seed_next = seed_wdata;
        end
        else if (cmd.lcg_step)
        begin
            seed_next = lcg_next;
        end
    end

    // Centred draw 2r-32767 as sign and magnitude
    assign dev_neg = ~draw[14];
    assign dev_mag = draw[14] ? {draw[13:0], 1'b1} : ~{draw[13:0], 1'b0};

    always_comb
    begin
        case ({cmd.chan, cmd.spike_sel})
            2'b00:   range_sel = cfg.temp_noise_range;
            2'b01:   range_sel = cfg.temp_spike_range;
            2'b10:   range_sel = cfg.pres_noise_range;
            default: range_sel = cfg.pres_spike_range;
        endcase
    end

    // Divide magnitude by 2^15-1: fold the high part back twice, then correct once
    assign q0   = prod_mag_reg[30:15];
    assign r0   = {2'b00, prod_mag_reg[14:0]} + {1'b0, q0};
    assign q1   = r0[16:15];
    assign r1   = {1'b0, r0[14:0]} + {14'd0, q1};
    assign quot = {1'b0, q0} + {15'd0, q1}
                  + {16'd0, (r1 >= {1'b0, rwss_pkg::DRAW_FULL})};

    // r mod 100 via reciprocal quotient, then remainder and compare
    assign recip_prod    = {13'd0, draw} * {15'd0, rwss_pkg::RECIP_100};
    assign q_times_100   = {1'b0, modq_reg, 6'd0} + {2'b00, modq_reg, 5'd0}
                           + {5'd0, modq_reg, 2'd0};
    assign rem_full      = draw - q_times_100[14:0];
    assign rem           = rem_full[6:0];
    assign sts.spike_hit = (rem < cfg.spike_percent);

    // Walk accumulator: noise step adds drift and clamps, spike step saturates
    assign val_ext   = (cmd.chan == rwss_pkg::CHAN_PRES) ? 19'(pres_reg) : 19'(temp_reg);
    assign drift_ext = (cmd.chan == rwss_pkg::CHAN_PRES) ? 19'(cfg.pres_drift)
                                                         : 19'(cfg.temp_drift);
    assign acc_sum   = val_ext + (cmd.acc_noise ? drift_ext : 19'sd0) + 19'(dev_reg);

    always_comb
    begin
        case ({cmd.chan, cmd.acc_noise})
            2'b01:   begin lo_bound = rwss_pkg::TEMP_MIN;     hi_bound = rwss_pkg::TEMP_MAX;     end
            2'b00:   begin lo_bound = rwss_pkg::TEMP_SAT_MIN; hi_bound = rwss_pkg::TEMP_SAT_MAX; end
            2'b11:   begin lo_bound = rwss_pkg::PRES_MIN;     hi_bound = rwss_pkg::PRES_MAX;     end
            default: begin lo_bound = rwss_pkg::PRES_SAT_MIN; hi_bound = rwss_pkg::PRES_SAT_MAX; end
        endcase
        if (acc_sum < lo_bound)
        begin
            acc_bounded = lo_bound;
        end
        else if (acc_sum > hi_bound)
        begin
            acc_bounded = hi_bound;
        end
        else
        begin
            acc_bounded = acc_sum;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= rwss_pkg::SEED_START_RST;
            temp_reg <= rwss_pkg::TEMP_VALUE_RST;
            pres_reg <= rwss_pkg::PRES_VALUE_RST;
        end
        else
        begin
            seed_reg <= seed_next;
            if (cmd.acc_noise || cmd.acc_spike)
            begin
                if (cmd.chan == rwss_pkg::CHAN_PRES)
                begin
                    pres_reg <= acc_bounded[13:0];
                end
                else
                begin
                    temp_reg <= acc_bounded[16:0];
                end
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.dev_mul)
        begin
            prod_mag_reg <= {16'd0, dev_mag} * {15'd0, range_sel};
            prod_neg_reg <= dev_neg;
        end
        if (cmd.dev_div)
        begin
            dev_reg <= prod_neg_reg ? -$signed(quot) : $signed(quot);
        end
        if (cmd.mod_q)
        begin
            modq_reg <= recip_prod[27:19];
        end
        if (cmd.mod_test)
        begin
            if (cmd.chan == rwss_pkg::CHAN_PRES)
            begin
                pres_flag_reg <= sts.spike_hit;
            end
            else
            begin
                temp_flag_reg <= sts.spike_hit;
            end
        end
        if (cmd.load_out)
        begin
            temperature_reg <= temp_reg;
            pressure_reg    <= pres_reg;
            temp_spiked_reg <= temp_flag_reg;
            pres_spiked_reg <= pres_flag_reg;
        end
    end

    assign temperature = temperature_reg;
    assign pressure    = pressure_reg;
    assign temp_spiked = temp_spiked_reg;
    assign pres_spiked = pres_spiked_reg;

endmodule

// ===== hdl/rwss_ctrl.sv =====
// Sequencer for one tick: noise, spike test and optional spike per channel,
// then the result beat. Depends on rwss_pkg for state_t, cmd_t and sts_t.
`timescale 1ns / 1ps

module rwss_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    input  rwss_pkg::sts_t      sts,
    output rwss_pkg::cmd_t      cmd
);

    rwss_pkg::state_t state_reg, state_next;
    logic             chan_reg, chan_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_beat;

    assign in_ready  = (state_reg == rwss_pkg::S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwss_pkg::S_IDLE;
            chan_reg      <= rwss_pkg::CHAN_TEMP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            rwss_pkg::S_IDLE:
            begin
                if (in_beat && advance)
                begin
                    chan_next  = rwss_pkg::CHAN_TEMP;
                    state_next = rwss_pkg::S_NLCG;
                end
            end
            rwss_pkg::S_NLCG:
            begin
                cmd.lcg_step = 1'b1;
                state_next   = rwss_pkg::S_NMUL;
            end
            rwss_pkg::S_NMUL:
            begin
                cmd.dev_mul = 1'b1;
                state_next  = rwss_pkg::S_NDIV;
            end
            rwss_pkg::S_NDIV:
            begin
                cmd.dev_div = 1'b1;
                state_next  = rwss_pkg::S_NACC;
            end
            rwss_pkg::S_NACC:
            begin
                cmd.acc_noise = 1'b1;
                state_next    = rwss_pkg::S_SLCG;
            end
            rwss_pkg::S_SLCG:
            begin
                cmd.lcg_step = 1'b1;
                state_next   = rwss_pkg::S_MODQ;
            end
            rwss_pkg::S_MODQ:
            begin
                cmd.mod_q  = 1'b1;
                state_next = rwss_pkg::S_MODT;
            end
            rwss_pkg::S_MODT:
            begin
                cmd.mod_test = 1'b1;
                if (sts.spike_hit)
                begin
                    state_next = rwss_pkg::S_XLCG;
                end
                else if (chan_reg == rwss_pkg::CHAN_TEMP)
                begin
                    chan_next  = rwss_pkg::CHAN_PRES;
                    state_next = rwss_pkg::S_NLCG;
                end
                else
                begin
                    state_next = rwss_pkg::S_DONE;
                end
            end
            rwss_pkg::S_XLCG:
            begin
                cmd.lcg_step = 1'b1;
                state_next   = rwss_pkg::S_XMUL;
            end
            rwss_pkg::S_XMUL:
            begin
                cmd.dev_mul   = 1'b1;
                cmd.spike_sel = 1'b1;
                state_next    = rwss_pkg::S_XDIV;
            end
            rwss_pkg::S_XDIV:
            begin
                cmd.dev_div = 1'b1;
                state_next  = rwss_pkg::S_XACC;
            end
            rwss_pkg::S_XACC:
            begin
                cmd.acc_spike = 1'b1;
                if (chan_reg == rwss_pkg::CHAN_TEMP)
                begin
                    chan_next  = rwss_pkg::CHAN_PRES;
                    state_next = rwss_pkg::S_NLCG;
                end
                else
                begin
                    state_next = rwss_pkg::S_DONE;
                end
            end
            rwss_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rwss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rwss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/random_walk_sensor_stimulus.sv =====
// Random-walk sensor stimulus: every accepted input beat with advance high
// yields one output beat carrying a temperature (17-bit signed, 1/256 degree)
// and a pressure (14-bit signed, 1/256 bar) reading plus two spike flags.
// A 31-bit LCG supplies 15-bit draws; each channel moves by drift plus a
// noise deviation (2r-32767)*range/32767 (truncating toward zero), is
// clamped (temperature -10..120 degrees, pressure 0..15 bar), and when a
// draw mod 100 falls below spike_percent a spike deviation is added and the
// value saturated to the output width. Temperature is worked before
// pressure. One shared multiply/divide unit and a single generator are
// stepped by a sequencer through the noise step, spike test and any spike
// of each channel, then a final step registers the result; a new input beat
// is taken only once that step is done. A beat with advance low is taken
// and dropped with no result. The result sits in an output register,
// so the next input beat is taken while it waits; the sequencer only holds at
// its final step if the previous result is still untaken. Registers sit on an
// APB-style port at 4*index; writing seed_start also reloads the generator.
// Write registers only while the block is idle.
// Depends on rwss_pkg, rwss_regs, rwss_ctrl and rwss_datapath.
`timescale 1ns / 1ps

module random_walk_sensor_stimulus
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                advance,
    // output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [16:0]  temperature,
    output logic signed [13:0]  pressure,
    output logic                temp_spiked,
    output logic                pres_spiked
);

    rwss_pkg::cfg_t cfg;
    rwss_pkg::cmd_t cmd;
    rwss_pkg::sts_t sts;
    logic           seed_load;
    logic [30:0]    seed_wdata;

    // Register file; a seed write is forwarded to the generator at once
    rwss_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .seed_load  (seed_load),
        .seed_wdata (seed_wdata)
    );

    // Sequencer: owns both handshakes and steps the datapath
    rwss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic, walk state and result register
    rwss_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .seed_load   (seed_load),
        .seed_wdata  (seed_wdata),
        .cmd         (cmd),
        .sts         (sts),
        .temperature (temperature),
        .pressure    (pressure),
        .temp_spiked (temp_spiked),
        .pres_spiked (pres_spiked)
    );

    // Without a spike the reading must lie inside its clamp window
    a_temp_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !temp_spiked) |->
        (temperature >= rwss_pkg::TEMP_MIN && temperature <= rwss_pkg::TEMP_MAX))
        else $error("temperature outside clamp window without spike");

    a_pres_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pres_spiked) |->
        (pressure >= rwss_pkg::PRES_MIN && pressure <= rwss_pkg::PRES_MAX))
        else $error("pressure outside clamp window without spike");

    // An advance beat starts the sequence, so the input side closes
    a_busy_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && advance) |=> !in_ready)
        else $error("input still open after an advance beat");

    // A beat without advance is dropped and the block stays open
    a_idle_after_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !advance) |=> in_ready)
        else $error("block went busy on a beat without advance");

    // No result beat can appear right after an advance beat is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && advance && !out_valid) |=> !out_valid)
        else $error("result appeared too early");

endmodule

// ===== verif/random_walk_sensor_stimulus_tb.sv =====
// Self-checking testbench for the random-walk sensor stimulus block.
// Drives valid/ready beats and APB register writes, predicts every reading.
// Depends on rwss_pkg and random_walk_sensor_stimulus.
`timescale 1ns / 1ps

module random_walk_sensor_stimulus_tb;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel and no register access
    localparam int SETTLE_CYCLES  = 32;    // longer than the sequencer's worst-case run
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 118;   // advancing beats per random phase

    typedef struct packed {
        logic signed [16:0] temperature;
        logic signed [13:0] pressure;
        logic               temp_spiked;
        logic               pres_spiked;
    } reading_t;

    // One row of the directed table: either a register write or an input beat,
    // the latter optionally carrying a reading that is known by inspection.
    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        logic        adv;
        logic        known;
        reading_t    want;
    } dir_row_t;

    typedef enum int {CFG_DEFAULT, CFG_MODERATE, CFG_WILD, CFG_EXTREME} cfg_kind_e;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               advance;
    logic               out_valid;
    logic               out_ready;
    logic signed [16:0] temperature;
    logic signed [13:0] pressure;
    logic               temp_spiked;
    logic               pres_spiked;

    // Predictor state: shadow registers, generator and both walk levels
    rwss_pkg::cfg_t shadow_cfg;
    logic [30:0]    gen_seed;
    longint         temp_level;
    longint         pres_level;

    reading_t    expected_readings[$];
    dir_row_t    directed_rows[$];

    // Known reading for the beat currently offered, sampled on acceptance
    logic        next_known;
    reading_t    next_want;

    logic        long_hold_req;
    int          mismatches;
    int          idle_cycles;
    int          beats_taken;
    int          beats_dropped;
    int          readings_seen;
    int          reg_writes;

    random_walk_sensor_stimulus i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .temperature (temperature),
        .pressure    (pressure),
        .temp_spiked (temp_spiked),
        .pres_spiked (pres_spiked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Step the 31-bit generator and return bits 30..16 of the new seed.
    function automatic logic [14:0] lcg_draw();
        logic [63:0] prod;
        prod = 64'(gen_seed) * 64'(rwss_pkg::LCG_MUL) + 64'(rwss_pkg::LCG_ADD);
        gen_seed = prod[30:0];
        return gen_seed[30:16];
    endfunction

    // Centred draw scaled to an amplitude; SV signed division truncates to zero.
    function automatic longint scaled_dev(logic [15:0] amplitude);
        longint centred;
        centred = 2 * longint'(lcg_draw()) - 32767;
        return (centred * longint'(amplitude)) / 32767;
    endfunction

    function automatic longint bound(longint v, longint lo, longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Noise step, clamp, spike test, optional spike, then saturate to the port.
    function automatic longint walk_step(longint level, logic signed [15:0] drift,
                                         logic [15:0] noise, logic [15:0] spike,
                                         longint lo, longint hi,
                                         longint sat_lo, longint sat_hi,
                                         output logic spiked);
        longint      v;
        logic [14:0] d;
        v = level + longint'(drift);
        v = v + scaled_dev(noise);
        v = bound(v, lo, hi);
        d = lcg_draw();
        spiked = (longint'(d) % 100) < longint'(shadow_cfg.spike_percent);
        if (spiked)
        begin
            v = v + scaled_dev(spike);
        end
        return bound(v, sat_lo, sat_hi);
    endfunction

    // Temperature is worked first, then pressure: the draw order matters.
    function automatic reading_t predict_reading();
        reading_t r;
        logic     ts;
        logic     ps;
        temp_level = walk_step(temp_level, shadow_cfg.temp_drift,
                               shadow_cfg.temp_noise_range, shadow_cfg.temp_spike_range,
                               rwss_pkg::TEMP_MIN, rwss_pkg::TEMP_MAX,
                               rwss_pkg::TEMP_SAT_MIN, rwss_pkg::TEMP_SAT_MAX, ts);
        pres_level = walk_step(pres_level, shadow_cfg.pres_drift,
                               shadow_cfg.pres_noise_range, shadow_cfg.pres_spike_range,
                               rwss_pkg::PRES_MIN, rwss_pkg::PRES_MAX,
                               rwss_pkg::PRES_SAT_MIN, rwss_pkg::PRES_SAT_MAX, ps);
        r.temperature = temp_level[16:0];
        r.pressure    = pres_level[13:0];
        r.temp_spiked = ts;
        r.pres_spiked = ps;
        return r;
    endfunction

    function automatic void reset_predictor();
        shadow_cfg.seed_start       = rwss_pkg::SEED_START_RST;
        shadow_cfg.temp_drift       = rwss_pkg::TEMP_DRIFT_RST;
        shadow_cfg.temp_noise_range = rwss_pkg::TEMP_NOISE_RANGE_RST;
        shadow_cfg.temp_spike_range = rwss_pkg::TEMP_SPIKE_RANGE_RST;
        shadow_cfg.pres_drift       = rwss_pkg::PRES_DRIFT_RST;
        shadow_cfg.pres_noise_range = rwss_pkg::PRES_NOISE_RANGE_RST;
        shadow_cfg.pres_spike_range = rwss_pkg::PRES_SPIKE_RANGE_RST;
        shadow_cfg.spike_percent    = rwss_pkg::SPIKE_PERCENT_RST;
        gen_seed   = rwss_pkg::SEED_START_RST;
        temp_level = longint'(rwss_pkg::TEMP_VALUE_RST);
        pres_level = longint'(rwss_pkg::PRES_VALUE_RST);
    endfunction

    // Mirror a register write; a seed write also reloads the generator.
    function automatic void store_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            rwss_pkg::REG_SEED_START:
            begin
                shadow_cfg.seed_start = val[30:0];
                gen_seed              = val[30:0];
            end
            rwss_pkg::REG_TEMP_DRIFT:       shadow_cfg.temp_drift       = val[15:0];
            rwss_pkg::REG_TEMP_NOISE_RANGE: shadow_cfg.temp_noise_range = val[15:0];
            rwss_pkg::REG_TEMP_SPIKE_RANGE: shadow_cfg.temp_spike_range = val[15:0];
            rwss_pkg::REG_PRES_DRIFT:       shadow_cfg.pres_drift       = val[15:0];
            rwss_pkg::REG_PRES_NOISE_RANGE: shadow_cfg.pres_noise_range = val[15:0];
            rwss_pkg::REG_PRES_SPIKE_RANGE: shadow_cfg.pres_spike_range = val[15:0];
            rwss_pkg::REG_SPIKE_PERCENT:    shadow_cfg.spike_percent    = val[6:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_image(logic [2:0] idx);
        case (idx)
            rwss_pkg::REG_SEED_START:       return 32'(shadow_cfg.seed_start);
            rwss_pkg::REG_TEMP_DRIFT:       return {16'd0, shadow_cfg.temp_drift};
            rwss_pkg::REG_TEMP_NOISE_RANGE: return 32'(shadow_cfg.temp_noise_range);
            rwss_pkg::REG_TEMP_SPIKE_RANGE: return 32'(shadow_cfg.temp_spike_range);
            rwss_pkg::REG_PRES_DRIFT:       return {16'd0, shadow_cfg.pres_drift};
            rwss_pkg::REG_PRES_NOISE_RANGE: return 32'(shadow_cfg.pres_noise_range);
            rwss_pkg::REG_PRES_SPIKE_RANGE: return 32'(shadow_cfg.pres_spike_range);
            default:                        return 32'(shadow_cfg.spike_percent);
        endcase
    endfunction

    // Compare read-back data only over the register's own width, since the
    // upper bits of a signed register may read back either way.
    function automatic logic [31:0] reg_mask(logic [2:0] idx);
        case (idx)
            rwss_pkg::REG_SEED_START:    return 32'h7FFF_FFFF;
            rwss_pkg::REG_SPIKE_PERCENT: return 32'h0000_007F;
            default:                     return 32'h0000_FFFF;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check the output beat first, then predict the input beat
    // taken at the same edge. Values are read before any update of the edge.
    // ------------------------------------------------------------------

    task automatic check_field(string what, longint want, longint got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.temperature = temperature;
                got.pressure    = pressure;
                got.temp_spiked = temp_spiked;
                got.pres_spiked = pres_spiked;
                readings_seen++;
                if (expected_readings.size() == 0)
                begin
                    $display("%0t ns: reading with none expected, actual %0d / %0d", $time,
                             got.temperature, got.pressure);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("temperature", want.temperature, got.temperature);
                    check_field("pressure", want.pressure, got.pressure);
                    check_field("temp_spiked", want.temp_spiked, got.temp_spiked);
                    check_field("pres_spiked", want.pres_spiked, got.pres_spiked);
                end
            end
            if (in_valid && in_ready)
            begin
                beats_taken++;
                if (advance)
                begin
                    // Run the predictor even for known rows to keep its state in step
                    want = predict_reading();
                    if (next_known)
                    begin
                        want = next_want;
                    end
                    expected_readings.push_back(want);
                end
                else
                begin
                    beats_dropped++;
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern that is chosen anew at random intervals,
    // and hold off for a long stretch when asked, so the block backs up.
    // ------------------------------------------------------------------

    initial
    begin : receiver
        rx_mode_e mode;
        int       mode_left;
        int       tick;
        out_ready = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                // Hold ready low while the sender keeps offering beats
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                    default:    out_ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration tasks; everything changes on the falling edge.
    // ------------------------------------------------------------------

    // Offer one beat and hold it until it is taken.
    task automatic send_beat(logic adv, logic known, reading_t want);
        @(negedge clk);
        in_valid   <= 1'b1;
        advance    <= adv;
        next_known <= known;
        next_want  <= want;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid, wait for every reading, then let a dropped beat finish too.
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write, then read back over the same address.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        store_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (((prdata ^ reg_image(idx)) & reg_mask(idx)) !== 32'd0)
        begin
            $display("%0t ns: register %0d read-back mismatch, expected %0h, actual %0h",
                     $time, idx, reg_image(idx) & reg_mask(idx), prdata & reg_mask(idx));
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all eight registers with one setting of the chosen kind.
    task automatic configure_phase(cfg_kind_e kind);
        logic [31:0] v [8];
        v[rwss_pkg::REG_SEED_START] = 32'($urandom() & 32'h7FFF_FFFF);
        case (kind)
            CFG_DEFAULT:
            begin
                v[rwss_pkg::REG_TEMP_DRIFT]       = 32'(rwss_pkg::TEMP_DRIFT_RST);
                v[rwss_pkg::REG_TEMP_NOISE_RANGE] = 32'(rwss_pkg::TEMP_NOISE_RANGE_RST);
                v[rwss_pkg::REG_TEMP_SPIKE_RANGE] = 32'(rwss_pkg::TEMP_SPIKE_RANGE_RST);
                v[rwss_pkg::REG_PRES_DRIFT]       = 32'(rwss_pkg::PRES_DRIFT_RST);
                v[rwss_pkg::REG_PRES_NOISE_RANGE] = 32'(rwss_pkg::PRES_NOISE_RANGE_RST);
                v[rwss_pkg::REG_PRES_SPIKE_RANGE] = 32'(rwss_pkg::PRES_SPIKE_RANGE_RST);
                v[rwss_pkg::REG_SPIKE_PERCENT]    = 32'(rwss_pkg::SPIKE_PERCENT_RST);
            end
            CFG_MODERATE:
            begin
                v[rwss_pkg::REG_TEMP_DRIFT]       = $urandom_range(0, 600) - 300;
                v[rwss_pkg::REG_TEMP_NOISE_RANGE] = $urandom_range(0, 2048);
                v[rwss_pkg::REG_TEMP_SPIKE_RANGE] = $urandom_range(0, 8000);
                v[rwss_pkg::REG_PRES_DRIFT]       = $urandom_range(0, 200) - 100;
                v[rwss_pkg::REG_PRES_NOISE_RANGE] = $urandom_range(0, 512);
                v[rwss_pkg::REG_PRES_SPIKE_RANGE] = $urandom_range(0, 2000);
                v[rwss_pkg::REG_SPIKE_PERCENT]    = $urandom_range(0, 30);
            end
            CFG_WILD:
            begin
                // Full 32-bit words: the block keeps only the register's width
                v[rwss_pkg::REG_SEED_START]       = $urandom();
                v[rwss_pkg::REG_TEMP_DRIFT]       = $urandom();
                v[rwss_pkg::REG_TEMP_NOISE_RANGE] = $urandom();
                v[rwss_pkg::REG_TEMP_SPIKE_RANGE] = $urandom();
                v[rwss_pkg::REG_PRES_DRIFT]       = $urandom();
                v[rwss_pkg::REG_PRES_NOISE_RANGE] = $urandom();
                v[rwss_pkg::REG_PRES_SPIKE_RANGE] = $urandom();
                v[rwss_pkg::REG_SPIKE_PERCENT]    = $urandom();
            end
            default:
            begin
                v[rwss_pkg::REG_SEED_START] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0;
                v[rwss_pkg::REG_TEMP_DRIFT] = $urandom_range(0, 1) ? 32'hFFFF_8000 : 32'h7FFF;
                v[rwss_pkg::REG_TEMP_NOISE_RANGE] = $urandom_range(0, 1) ? 32'hFFFF : 32'd0;
                v[rwss_pkg::REG_TEMP_SPIKE_RANGE] = $urandom_range(0, 1) ? 32'hFFFF : 32'd0;
                v[rwss_pkg::REG_PRES_DRIFT] = $urandom_range(0, 1) ? 32'hFFFF_8000 : 32'h7FFF;
                v[rwss_pkg::REG_PRES_NOISE_RANGE] = $urandom_range(0, 1) ? 32'hFFFF : 32'd0;
                v[rwss_pkg::REG_PRES_SPIKE_RANGE] = $urandom_range(0, 1) ? 32'hFFFF : 32'd0;
                v[rwss_pkg::REG_SPIKE_PERCENT] = $urandom_range(0, 1) ? 32'd100 : 32'd0;
            end
        endcase
        for (int i = 0; i < 8; i++)
        begin
            write_reg(3'(i), v[i]);
        end
    endtask

    // Bursts of back-to-back beats with random gaps; a few beats carry no advance.
    task automatic run_random_phase(int items, logic hold, logic pause);
        int   sent;
        int   burst_left;
        int   gap;
        logic adv;
        sent       = 0;
        burst_left = $urandom_range(1, 24);
        while (sent < items)
        begin
            if (hold && sent == 10 && !long_hold_req)
            begin
                long_hold_req = 1'b1;
            end
            if (pause && sent == items / 2)
            begin
                // Pause until every outstanding reading has come back
                @(negedge clk);
                in_valid <= 1'b0;
                while (expected_readings.size() != 0) @(posedge clk);
                pause = 1'b0;
            end
            adv = ($urandom_range(0, 11) != 0);
            send_beat(adv, 1'b0, '0);
            if (adv)
            begin
                sent++;
            end
            burst_left--;
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    task automatic row_cfg(logic [2:0] idx, logic [31:0] val);
        dir_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = val;
        directed_rows.push_back(r);
    endtask

    task automatic row_beat(logic adv);
        dir_row_t r;
        r     = '0;
        r.adv = adv;
        directed_rows.push_back(r);
    endtask

    task automatic row_known(int t, int p, logic ts, logic ps);
        dir_row_t r;
        r                  = '0;
        r.adv              = 1'b1;
        r.known            = 1'b1;
        r.want.temperature = t[16:0];
        r.want.pressure    = p[13:0];
        r.want.temp_spiked = ts;
        r.want.pres_spiked = ps;
        directed_rows.push_back(r);
    endtask

    task automatic build_directed_rows();
        // First readings after reset, with a dropped beat in between
        row_beat(1'b1);
        row_beat(1'b0);
        row_beat(1'b1);
        // No noise and no spikes: the largest drift drives both to their top bounds
        row_cfg(rwss_pkg::REG_TEMP_NOISE_RANGE, 32'd0);
        row_cfg(rwss_pkg::REG_PRES_NOISE_RANGE, 32'd0);
        row_cfg(rwss_pkg::REG_SPIKE_PERCENT, 32'd0);
        row_cfg(rwss_pkg::REG_TEMP_DRIFT, 32'h7FFF);
        row_cfg(rwss_pkg::REG_PRES_DRIFT, 32'h7FFF);
        row_known(30720, 3840, 1'b0, 1'b0);
        row_known(30720, 3840, 1'b0, 1'b0);
        // Most negative drift: temperature steps from its top bound to 30720-32768,
        // pressure hits its lower bound, then both sit at their lower bounds
        row_cfg(rwss_pkg::REG_TEMP_DRIFT, 32'hFFFF_8000);
        row_cfg(rwss_pkg::REG_PRES_DRIFT, 32'hFFFF_8000);
        row_known(-2048, 0, 1'b0, 1'b0);
        row_beat(1'b0);
        row_known(-2560, 0, 1'b0, 1'b0);
        // Every tick spikes, but with zero amplitude the levels stay put
        row_cfg(rwss_pkg::REG_TEMP_SPIKE_RANGE, 32'd0);
        row_cfg(rwss_pkg::REG_PRES_SPIKE_RANGE, 32'd0);
        row_cfg(rwss_pkg::REG_SPIKE_PERCENT, 32'd100);
        row_known(-2560, 0, 1'b1, 1'b1);
        // A percentage above one hundred also spikes every tick
        row_cfg(rwss_pkg::REG_SPIKE_PERCENT, 32'd127);
        row_known(-2560, 0, 1'b1, 1'b1);
        // Full-scale spikes from both bounds: saturation to the port range
        row_cfg(rwss_pkg::REG_TEMP_SPIKE_RANGE, 32'hFFFF);
        row_cfg(rwss_pkg::REG_PRES_SPIKE_RANGE, 32'hFFFF);
        row_beat(1'b1);
        row_beat(1'b1);
        row_beat(1'b1);
        row_cfg(rwss_pkg::REG_TEMP_DRIFT, 32'h7FFF);
        row_cfg(rwss_pkg::REG_PRES_DRIFT, 32'h7FFF);
        row_beat(1'b1);
        row_beat(1'b1);
        row_beat(1'b1);
        // Seed extremes
        row_cfg(rwss_pkg::REG_SEED_START, 32'd0);
        row_beat(1'b1);
        row_cfg(rwss_pkg::REG_SEED_START, 32'h7FFF_FFFF);
        row_beat(1'b1);
        // Full-scale noise with no drift, about half the ticks spiking
        row_cfg(rwss_pkg::REG_TEMP_DRIFT, 32'd0);
        row_cfg(rwss_pkg::REG_PRES_DRIFT, 32'd0);
        row_cfg(rwss_pkg::REG_TEMP_NOISE_RANGE, 32'hFFFF);
        row_cfg(rwss_pkg::REG_PRES_NOISE_RANGE, 32'hFFFF);
        row_cfg(rwss_pkg::REG_SPIKE_PERCENT, 32'd50);
        row_beat(1'b1);
        row_beat(1'b1);
        row_beat(1'b1);
        row_beat(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        dir_row_t row;
        logic     beats_pending;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        advance       = 1'b0;
        next_known    = 1'b0;
        next_want     = '0;
        long_hold_req = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        beats_taken   = 0;
        beats_dropped = 0;
        readings_seen = 0;
        reg_writes    = 0;
        beats_pending = 1'b0;
        reset_predictor();
        build_directed_rows();

        // Hold reset low, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; drain the block before a register write that follows beats
        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.is_cfg)
            begin
                if (beats_pending)
                begin
                    settle_idle();
                    beats_pending = 1'b0;
                end
                write_reg(row.reg_idx, row.value);
            end
            else
            begin
                send_beat(row.adv, row.known, row.want);
                beats_pending = 1'b1;
            end
        end
        settle_idle();

        // Random phases, each under a fresh setting of every register
        for (int p = 0; p < PHASES; p++)
        begin
            configure_phase(cfg_kind_e'(p % 4));
            run_random_phase(PHASE_ITEMS, (p == 1) || (p == 6), (p == 4) || (p == 9));
            settle_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats (%0d without advance) and %0d register writes",
                 beats_taken, beats_dropped, reg_writes);
        $display("Compared %0d readings across %0d random settings plus the directed rows",
                 readings_seen, PHASES);
        if (mismatches == 0 && expected_readings.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            if (expected_readings.size() != 0)
            begin
                $display("%0d expected readings never arrived", expected_readings.size());
            end
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
